// ----- design/mmf_pkg.sv -----
// Package with the shared types and constants of the median filter.
`timescale 1ns / 1ps

package mmf_pkg;

   // Widths of the channel tag and of one sample.
   localparam int CHAN_W = 2;
   localparam int DATA_W = 16;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [CHAN_W-1:0]        chan_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   // Control for one compare of the rank scan.
   // It travels alongside the registered read data of the ring memory.
   typedef struct packed {
      logic valid;   // a compare is due in this cycle
      logic first;   // first comparand of a candidate, so the count restarts
      logic last;    // last comparand of a candidate, so the count is final
      logic lower;   // comparand index is below the candidate index
   } rank_ctl_type;

endpackage

// ----- design/mmf_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface mmf_req_if;
   logic                 valid;
   logic                 ready;
   mmf_pkg::chan_type    channel;
   mmf_pkg::sample_type  sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mmf_rsp_if;
   logic                 valid;
   logic                 ready;
   mmf_pkg::sample_type  median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

// ----- design/mmf_ring_mem.sv -----
// Sample ring memory with one write port, two registered read ports and entry valid bits.
`timescale 1ns / 1ps

module mmf_ring_mem #(
   parameter int DEPTH = 20,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mmf_pkg::sample_type wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output mmf_pkg::sample_type rd_data_a,
   output mmf_pkg::sample_type rd_data_b
);

   mmf_pkg::sample_type mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   mmf_pkg::sample_type rd_a_ff;
   mmf_pkg::sample_type rd_b_ff;
   logic                vld_a_ff;
   logic                vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_a_ff <= valid_ff[rd_addr_a];
         vld_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = vld_a_ff ? rd_a_ff : '0;
   assign rd_data_b = vld_b_ff ? rd_b_ff : '0;

endmodule

// ----- design/mmf_rank_unit.sv -----
// Shared signed comparator and rank counter that tests one candidate per window pass.
`timescale 1ns / 1ps

module mmf_rank_unit #(
   parameter int WINDOW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mmf_pkg::rank_ctl_type ctl,
   input  mmf_pkg::sample_type   cand,
   input  mmf_pkg::sample_type   other,
   output logic                  hit,
   output mmf_pkg::sample_type   hit_value
);

   localparam int CNTW = (WINDOW > 1) ? $clog2(WINDOW + 1) : 1;
   localparam logic [CNTW-1:0] MID = CNTW'(WINDOW / 2);

   logic [CNTW-1:0] cnt_ff;
   logic [CNTW-1:0] cnt_in;
   logic            below;

   // The comparand sorts ahead of the candidate when it is smaller, or
   // equal and stored at a lower index, which gives every entry a distinct rank.
   assign below  = (other < cand) || ((other == cand) && ctl.lower);
   assign cnt_in = (ctl.first ? '0 : cnt_ff) + CNTW'(below);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.valid) begin
         cnt_ff <= cnt_in;
      end
   end

   assign hit       = ctl.valid && ctl.last && (cnt_in == MID);
   assign hit_value = cand;

endmodule

// ----- design/multichannel_median_filter_unit.sv -----
// Top level of the multichannel sliding-window median filter.
//
//  Channel   Port      Direction  Payload
//  request   req_port  in         channel (2 bits), sample (16 bits, signed)
//  response  rsp_port  out        median (16 bits, signed)
//
// An accepted request first writes its sample into the channel's ring, then runs a
// rank scan of up to WINDOW*WINDOW compares on one shared comparator, one compare
// per cycle, through the registered read ports of the ring. The median found passes
// through the delivery state into the output register. A request for a channel at
// or above CHANNELS skips the write and the scan and goes straight to delivery with
// a zero result.
// Reset is synchronous and active high; it clears all ring entries to zero through
// per-entry valid bits and sets every write position to zero.
// The request side is ready only while the sequencer is idle. A finished median
// waits in the output register, so a stalled response side holds back the next
// result but not the acceptance of the next request.
`timescale 1ns / 1ps

module multichannel_median_filter_unit #(
   parameter int CHANNELS = 4,
   parameter int WINDOW   = 5
) (
   input  logic      clock,
   input  logic      reset,
   mmf_req_if.sink   req_port,
   mmf_rsp_if.source rsp_port
);

   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

   // Sequencer and item registers.
   mmf_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]         ch_ff, ch_in;
   logic [AW-1:0]         base_ff, base_in;
   mmf_pkg::sample_type   sample_ff, sample_in;
   logic [PW-1:0]         i_ff, i_in;
   logic [PW-1:0]         j_ff, j_in;
   mmf_pkg::sample_type   med_ff, med_in;
   mmf_pkg::rank_ctl_type ctl_ff, ctl_in;

   // Output register.
   logic                  rsp_vld_ff, rsp_vld_in;
   mmf_pkg::sample_type   rsp_med_ff, rsp_med_in;

   // Per-channel write positions.
   logic [PW-1:0]         pos_ff [CHANNELS];
   logic [PW-1:0]         pos_cur;
   logic [PW-1:0]         pos_nxt;

   // Memory and rank unit connections.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr_a;
   logic [AW-1:0]         rd_addr_b;
   mmf_pkg::sample_type   cand_data;
   mmf_pkg::sample_type   other_data;
   logic                  hit;
   mmf_pkg::sample_type   hit_value;

   logic                  req_fire;
   logic                  in_range;

   assign req_port.ready = (state_ff == mmf_pkg::ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign in_range       = (int'(req_port.channel) < CHANNELS);

   assign rsp_port.valid  = rsp_vld_ff;
   assign rsp_port.median = rsp_med_ff;

   // The write position of the current channel and where it moves next.
   assign pos_cur = pos_ff[ch_ff];
   assign pos_nxt = (pos_cur == LAST_POS) ? '0 : pos_cur + 1'b1;

   assign wr_addr   = base_ff + AW'(pos_cur);
   assign rd_addr_a = base_ff + AW'(i_ff);
   assign rd_addr_b = base_ff + AW'(j_ff);

   mmf_ring_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ring_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (sample_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (cand_data),
      .rd_data_b (other_data)
   );

   mmf_rank_unit #(
      .WINDOW (WINDOW)
   ) u_rank_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_ff),
      .cand      (cand_data),
      .other     (other_data),
      .hit       (hit),
      .hit_value (hit_value)
   );

   // Next state and datapath control. The scan walks candidate i over the
   // window and, for each candidate, comparand j over the window. The median
   // is the candidate with exactly WINDOW/2 entries sorted ahead of it.
   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      base_in    = base_ff;
      sample_in  = sample_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      med_in     = med_ff;
      ctl_in     = '0;
      wr_en      = 1'b0;
      rsp_vld_in = rsp_vld_ff;
      rsp_med_in = rsp_med_ff;

      if (rsp_vld_ff && rsp_port.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         mmf_pkg::ST_IDLE: begin
            if (req_fire) begin
               ch_in     = CW'(req_port.channel);
               base_in   = AW'(int'(req_port.channel) * WINDOW);
               sample_in = req_port.sample;
               if (in_range) begin
                  state_in = mmf_pkg::ST_WRITE;
               end else begin
                  med_in   = '0;
                  state_in = mmf_pkg::ST_DELIVER;
               end
            end
         end
         mmf_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            i_in     = '0;
            j_in     = '0;
            state_in = mmf_pkg::ST_SCAN;
         end
         mmf_pkg::ST_SCAN: begin
            if (hit) begin
               med_in   = hit_value;
               state_in = mmf_pkg::ST_DELIVER;
            end else begin
               ctl_in.valid = 1'b1;
               ctl_in.first = (j_ff == '0);
               ctl_in.last  = (j_ff == LAST_POS);
               ctl_in.lower = (j_ff < i_ff);
               if (j_ff == LAST_POS) begin
                  j_in = '0;
                  i_in = (i_ff == LAST_POS) ? '0 : i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         mmf_pkg::ST_DELIVER: begin
            if (!rsp_vld_ff || rsp_port.ready) begin
               rsp_vld_in = 1'b1;
               rsp_med_in = med_ff;
               state_in   = mmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mmf_pkg::ST_IDLE;
         ctl_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ctl_ff     <= ctl_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      base_ff    <= base_in;
      sample_ff  <= sample_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      med_ff     <= med_in;
      rsp_med_ff <= rsp_med_in;
   end

   // The write position of a channel advances once per sample it takes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
         end
      end else if (wr_en) begin
         pos_ff[ch_ff] <= pos_nxt;
      end
   end

   // An accepted request leads either to the ring write or straight to delivery.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == mmf_pkg::ST_WRITE || state_ff == mmf_pkg::ST_DELIVER))
      else $error("accepted request did not start a write or a delivery");

   // The candidate and comparand indices stay inside the window throughout the scan.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmf_pkg::ST_SCAN) |-> (i_ff <= LAST_POS && j_ff <= LAST_POS))
      else $error("scan index ran past the window");

   // A new result only appears in the output register out of the delivery state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !$past(rsp_vld_ff)) |-> ($past(state_ff) == mmf_pkg::ST_DELIVER))
      else $error("result loaded outside of delivery");

   // The ring write always lands inside the window of the current channel.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (pos_cur <= LAST_POS))
      else $error("write position out of range");

endmodule
